FILE: hdl/aot_pkg.sv
package aot_pkg;

    // Line-level limits and defaults.
    localparam int          MAX_OPS_LIMIT   = 8;
    localparam logic [3:0]  MAX_OPS_RESET   = 4'd4;
    localparam int          HOLD_DEPTH_DEF  = 8;
    localparam int          HOLD_CAP_MAX    = 10;
    localparam int          QUEUE_DEPTH_DEF = 2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_LBRK   = 8'h5B;
    localparam logic [7:0] CHAR_RBRK   = 8'h5D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_W      = 8'h77;
    localparam logic [7:0] CHAR_S      = 8'h73;
    localparam logic [7:0] CHAR_D      = 8'h64;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    // Result kinds.
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    // Operand types.
    localparam logic [2:0] TYPE_REG   = 3'd0;
    localparam logic [2:0] TYPE_IMM   = 3'd1;
    localparam logic [2:0] TYPE_MEM   = 3'd2;
    localparam logic [2:0] TYPE_ADDR  = 3'd3;
    localparam logic [2:0] TYPE_OTHER = 3'd4;

    // Operand parts.
    localparam logic [1:0] PART_PLAIN  = 2'd0;
    localparam logic [1:0] PART_BASE   = 2'd1;
    localparam logic [1:0] PART_OFFSET = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] operand_type;
        logic [1:0] part;
        logic [7:0] text_char;
        logic [2:0] operand_index;
        logic [3:0] operand_total;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        CH_PLAIN,
        CH_SEMI,
        CH_HASH,
        CH_LBRK,
        CH_RBRK,
        CH_COMMA,
        CH_X,
        CH_REGL,
        CH_ZERO,
        CH_SPACE
    } t_ch_code;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        t_ch_code   code;
        logic       is_ws;
        logic       is_alnum;
        logic       is_hex;
    } t_cls_item;

    typedef enum logic [2:0] {
        M_START,
        M_REG,
        M_IMM,
        M_MBASE,
        M_MOFF,
        M_ADDR,
        M_OTHER
    } t_mode;

    typedef enum logic [2:0] {
        PH_FEED,
        PH_FLUSH,
        PH_TOKC,
        PH_END,
        PH_LINE
    } t_phase;

    typedef enum logic [1:0] {
        P_TOK,
        P_CLOSE,
        P_CLOSE_CONT,
        P_MOFF
    } t_post;

    function automatic logic [2:0] mode_type(input t_mode m);
        logic [2:0] t;
        case (m)
            M_IMM:   t = TYPE_IMM;
            M_MBASE: t = TYPE_MEM;
            M_MOFF:  t = TYPE_MEM;
            M_ADDR:  t = TYPE_ADDR;
            M_OTHER: t = TYPE_OTHER;
            default: t = TYPE_REG;
        endcase
        return t;
    endfunction

    function automatic logic [1:0] mode_part(input t_mode m);
        logic [1:0] p;
        case (m)
            M_MBASE: p = PART_BASE;
            M_MOFF:  p = PART_OFFSET;
            default: p = PART_PLAIN;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/asm_operand_tokenizer_top.sv
// Assembly operand tokenizer. Each input transfer carries one character of
// an operand string, or an end-of-line mark. Operands are sorted into
// register, immediate, bracketed memory reference (base and offset parts),
// 0x address and other; every kept character leaves as a token result
// tagged with type, part and operand index, each operand ends with a close
// result, and each line ends with a line-finished result holding the
// operand count. last_of_run marks the final result caused by an input
// transfer; a transfer may cause no result at all. A front stage registers
// and classifies each character and places it in a short queue; the back
// engine takes items from that queue and produces at most one result per
// cycle through a one-entry pending slot and an output register, so the
// input keeps flowing until the queue fills while a result waits on a
// stalled output. The engine takes one step per cycle when not stalled and
// each step sends at most one result. A non-space character inside a
// memory reference or other token is sent after each held whitespace
// character ahead of it. A character that ends an operand without being
// used up is looked at again after the close result, and a pending zero
// is sent when the next character resolves it. A semicolon or zero byte
// closes any open operand and starts a comment; an end of line closes any
// open operand, then sends the line-finished result. The engine sets the
// throughput, so plain register, immediate and address characters run at
// one item per cycle while the output is not stalled. max_operands is
// written through the configuration channel, which is always ready; it
// must only be written while the block is idle.
module asm_operand_tokenizer_top #(
    parameter int HOLD_DEPTH  = aot_pkg::HOLD_DEPTH_DEF,
    parameter int QUEUE_DEPTH = aot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aot_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aot_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);
    import aot_pkg::*;

    logic [3:0] r_max_ops;
    logic       fq_valid;
    logic       fq_ready;
    t_cls_item  fq_data;
    logic       qe_valid;
    logic       qe_pop;
    t_cls_item  qe_data;

    // The single configuration register is taken on every valid transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ops <= MAX_OPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_ops <= i_cfg_data;
        end
    end

    // Front: input register and character classification.
    aot_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_data   (fq_data)
    );

    // Queue that lets the front and the engine stall independently.
    aot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fq_valid),
        .o_ready     (fq_ready),
        .i_push_data (fq_data),
        .o_valid     (qe_valid),
        .i_pop       (qe_pop),
        .o_data      (qe_data)
    );

    // Back: the operand state machine and result sequencer.
    aot_engine #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_ops   (r_max_ops),
        .i_q_valid   (qe_valid),
        .i_q_data    (qe_data),
        .o_q_pop     (qe_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hdl/aot_front.sv
module aot_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aot_pkg::t_in_item   i_in_data,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output aot_pkg::t_cls_item  o_q_data
);
    import aot_pkg::*;

    logic      r_vld;
    logic      n_vld;
    t_cls_item r_item;
    t_cls_item n_item;
    logic      accept;
    logic      is_digit;
    logic      is_alpha;
    logic [7:0] c;

    assign o_in_stall = r_vld && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_valid  = r_vld;
    assign o_q_data   = r_item;
    assign c          = i_in_data.ch;

    // Character classes; bytes of 128 and above fall into none of them.
    always_comb begin
        is_digit        = (c >= 8'h30) && (c <= 8'h39);
        is_alpha        = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
        n_item.ch       = c;
        n_item.is_end   = i_in_data.is_end;
        n_item.is_ws    = (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
        n_item.is_alnum = is_digit || is_alpha;
        n_item.is_hex   = is_digit || ((c >= 8'h61) && (c <= 8'h66))
                          || ((c >= 8'h41) && (c <= 8'h46));
        case (c)
            CHAR_SEMI:  n_item.code = CH_SEMI;
            CHAR_NUL:   n_item.code = CH_SEMI;
            CHAR_HASH:  n_item.code = CH_HASH;
            CHAR_LBRK:  n_item.code = CH_LBRK;
            CHAR_RBRK:  n_item.code = CH_RBRK;
            CHAR_COMMA: n_item.code = CH_COMMA;
            CHAR_X:     n_item.code = CH_X;
            CHAR_W:     n_item.code = CH_REGL;
            CHAR_S:     n_item.code = CH_REGL;
            CHAR_D:     n_item.code = CH_REGL;
            CHAR_ZERO:  n_item.code = CH_ZERO;
            CHAR_SPACE: n_item.code = CH_SPACE;
            default:    n_item.code = CH_PLAIN;
        endcase
        n_vld = accept || (r_vld && !i_q_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hdl/aot_queue.sv
module aot_queue #(
    parameter int DEPTH = aot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_ready,
    input  aot_pkg::t_cls_item  i_push_data,
    output logic                o_valid,
    input  logic                i_pop,
    output aot_pkg::t_cls_item  o_data
);
    import aot_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls_item       r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

FILE: hdl/aot_engine.sv
module aot_engine #(
    parameter int HOLD_DEPTH = aot_pkg::HOLD_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [3:0]          i_max_ops,
    input  logic                i_q_valid,
    input  aot_pkg::t_cls_item  i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aot_pkg::t_out_item  o_out_data
);
    import aot_pkg::*;

    localparam int HOLD_CAP = (HOLD_DEPTH < HOLD_CAP_MAX) ? HOLD_DEPTH : HOLD_CAP_MAX;
    localparam int HCW      = $clog2(HOLD_CAP + 1);
    localparam int HIW      = (HOLD_CAP > 1) ? $clog2(HOLD_CAP) : 1;

    // Line state.
    t_mode          r_mode,   n_mode;
    logic           r_zp,     n_zp;
    logic           r_skip,   n_skip;
    logic [3:0]     r_found,  n_found;
    logic           r_cmt,    n_cmt;
    logic [HCW-1:0] r_hcnt,   n_hcnt;
    logic           r_sp_vld, n_sp_vld;
    logic [HCW-1:0] r_sp_idx, n_sp_idx;
    logic [7:0]     r_held [HOLD_CAP];

    // Per-item sequencer.
    t_phase         r_ph,     n_ph;
    logic [HCW-1:0] r_fi,     n_fi;
    logic [HCW-1:0] r_fn,     n_fn;
    t_post          r_post,   n_post;

    // Pending result and output register.
    logic           r_p_vld,  n_p_vld;
    logic           r_p_last, n_p_last;
    t_out_item      r_p,      n_p;
    logic           r_o_vld,  n_o_vld;
    t_out_item      r_o,      n_o;

    logic           out_space;
    logic           go;
    logic           move;
    logic           e_emit;
    logic           e_done;
    t_out_item      e_res;
    logic           do_close;
    logic           hold_we;
    logic           limit_hit;
    logic [3:0]     lim;
    t_cls_item      it;

    function automatic t_out_item f_tok(input t_mode m, input logic [7:0] ch,
                                        input logic [3:0] idx);
        t_out_item r;
        r.kind          = KIND_TOKEN;
        r.operand_type  = mode_type(m);
        r.part          = mode_part(m);
        r.text_char     = ch;
        r.operand_index = idx[2:0];
        r.operand_total = 4'd0;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic t_out_item f_close(input t_mode m, input logic [3:0] idx);
        t_out_item r;
        r.kind          = KIND_CLOSE;
        r.operand_type  = mode_type(m);
        r.part          = PART_PLAIN;
        r.text_char     = 8'd0;
        r.operand_index = idx[2:0];
        r.operand_total = 4'd0;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic t_out_item f_line(input logic [3:0] total);
        t_out_item r;
        r.kind          = KIND_LINE;
        r.operand_type  = TYPE_REG;
        r.part          = PART_PLAIN;
        r.text_char     = 8'd0;
        r.operand_index = 3'd0;
        r.operand_total = total;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    assign it          = i_q_data;
    assign lim         = (int'(i_max_ops) > MAX_OPS_LIMIT) ? 4'(MAX_OPS_LIMIT) : i_max_ops;
    assign limit_hit   = (r_found >= lim);
    assign out_space   = !r_o_vld || !i_out_stall;
    assign go          = !r_p_vld || out_space;
    assign o_q_pop     = e_done;
    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o;

    always_comb begin
        n_mode   = r_mode;
        n_zp     = r_zp;
        n_skip   = r_skip;
        n_found  = r_found;
        n_cmt    = r_cmt;
        n_hcnt   = r_hcnt;
        n_sp_vld = r_sp_vld;
        n_sp_idx = r_sp_idx;
        n_ph     = r_ph;
        n_fi     = r_fi;
        n_fn     = r_fn;
        n_post   = r_post;
        e_emit   = 1'b0;
        e_done   = 1'b0;
        e_res    = f_line(4'd0);
        do_close = 1'b0;
        hold_we  = 1'b0;

        if (go && i_q_valid) begin
            case (r_ph)
                PH_FEED: begin
                    if (it.is_end) begin
                        n_ph = r_cmt ? PH_LINE : PH_END;
                    end else if (r_cmt) begin
                        e_done = 1'b1;
                    end else if (it.code == CH_SEMI) begin
                        n_ph = PH_END;
                    end else if (limit_hit) begin
                        e_done = 1'b1;
                    end else begin
                        case (r_mode)
                            M_START: begin
                                if (r_zp) begin
                                    n_zp   = 1'b0;
                                    e_emit = 1'b1;
                                    if (it.code == CH_X) begin
                                        n_mode = M_ADDR;
                                        e_res  = f_tok(M_ADDR, CHAR_ZERO, r_found);
                                        n_ph   = PH_TOKC;
                                    end else begin
                                        // The zero opens an other token and the
                                        // character is looked at again.
                                        n_mode = M_OTHER;
                                        e_res  = f_tok(M_OTHER, CHAR_ZERO, r_found);
                                    end
                                end else begin
                                    e_done = 1'b1;
                                    if (it.code == CH_X || it.code == CH_REGL) begin
                                        n_mode = M_REG;
                                        e_emit = 1'b1;
                                        e_res  = f_tok(M_REG, it.ch, r_found);
                                    end else if (it.code == CH_HASH) begin
                                        n_mode = M_IMM;
                                        e_emit = 1'b1;
                                        e_res  = f_tok(M_IMM, it.ch, r_found);
                                    end else if (it.code == CH_LBRK) begin
                                        n_mode   = M_MBASE;
                                        n_hcnt   = '0;
                                        n_sp_vld = 1'b0;
                                        n_skip   = 1'b0;
                                    end else if (it.code == CH_ZERO) begin
                                        n_zp = 1'b1;
                                    end else if (!it.is_ws) begin
                                        n_mode = M_OTHER;
                                        e_emit = 1'b1;
                                        e_res  = f_tok(M_OTHER, it.ch, r_found);
                                    end
                                end
                            end
                            M_REG, M_IMM, M_ADDR: begin
                                if ((r_mode == M_REG && it.is_alnum)
                                    || (r_mode == M_IMM && (it.is_hex || it.code == CH_X))
                                    || (r_mode == M_ADDR && it.is_hex)) begin
                                    e_emit = 1'b1;
                                    e_res  = f_tok(r_mode, it.ch, r_found);
                                    e_done = 1'b1;
                                end else begin
                                    // A comma is used up; anything else starts
                                    // the next operand.
                                    do_close = 1'b1;
                                    e_done   = (it.code == CH_COMMA);
                                end
                            end
                            M_MBASE, M_MOFF: begin
                                if (it.is_ws) begin
                                    e_done = 1'b1;
                                    if (!(r_mode == M_MOFF && r_skip)) begin
                                        hold_we = 1'b1;
                                    end
                                end else begin
                                    n_skip = 1'b0;
                                    n_ph   = PH_FLUSH;
                                    n_fi   = '0;
                                    n_fn   = r_hcnt;
                                    if (it.code == CH_RBRK) begin
                                        n_post = P_CLOSE;
                                    end else if (it.code == CH_COMMA && r_mode == M_MBASE) begin
                                        n_post = P_MOFF;
                                    end else begin
                                        n_post = P_TOK;
                                    end
                                end
                            end
                            default: begin
                                if (it.is_ws) begin
                                    e_done  = 1'b1;
                                    hold_we = 1'b1;
                                end else begin
                                    n_ph = PH_FLUSH;
                                    n_fi = '0;
                                    if (r_sp_vld) begin
                                        n_fn   = r_sp_idx;
                                        n_post = P_CLOSE_CONT;
                                    end else begin
                                        n_fn   = r_hcnt;
                                        n_post = (it.code == CH_COMMA) ? P_CLOSE : P_TOK;
                                    end
                                end
                            end
                        endcase
                    end
                end
                PH_FLUSH: begin
                    if (r_fi < r_fn) begin
                        e_emit = 1'b1;
                        e_res  = f_tok(r_mode, r_held[r_fi[HIW-1:0]], r_found);
                        n_fi   = r_fi + HCW'(1);
                    end else begin
                        n_hcnt   = '0;
                        n_sp_vld = 1'b0;
                        n_ph     = PH_FEED;
                        case (r_post)
                            P_CLOSE: begin
                                do_close = 1'b1;
                                e_done   = 1'b1;
                            end
                            P_CLOSE_CONT: begin
                                do_close = 1'b1;
                            end
                            P_MOFF: begin
                                n_mode = M_MOFF;
                                n_skip = 1'b1;
                                e_done = 1'b1;
                            end
                            default: begin
                                e_emit = 1'b1;
                                e_res  = f_tok(r_mode, it.ch, r_found);
                                e_done = 1'b1;
                            end
                        endcase
                    end
                end
                PH_TOKC: begin
                    e_emit = 1'b1;
                    e_res  = f_tok(r_mode, it.ch, r_found);
                    e_done = 1'b1;
                    n_ph   = PH_FEED;
                end
                PH_END: begin
                    if (!limit_hit && r_mode == M_START && r_zp) begin
                        n_mode = M_OTHER;
                        n_zp   = 1'b0;
                        e_emit = 1'b1;
                        e_res  = f_tok(M_OTHER, CHAR_ZERO, r_found);
                    end else if (!limit_hit && r_mode != M_START) begin
                        do_close = 1'b1;
                    end else begin
                        n_zp     = 1'b0;
                        n_hcnt   = '0;
                        n_sp_vld = 1'b0;
                        n_skip   = 1'b0;
                        n_mode   = M_START;
                        if (it.is_end) begin
                            n_ph = PH_LINE;
                        end else begin
                            n_cmt  = 1'b1;
                            e_done = 1'b1;
                            n_ph   = PH_FEED;
                        end
                    end
                end
                PH_LINE: begin
                    e_emit   = 1'b1;
                    e_res    = f_line(r_found);
                    e_done   = 1'b1;
                    n_ph     = PH_FEED;
                    n_mode   = M_START;
                    n_zp     = 1'b0;
                    n_skip   = 1'b0;
                    n_found  = 4'd0;
                    n_cmt    = 1'b0;
                    n_hcnt   = '0;
                    n_sp_vld = 1'b0;
                end
                default: begin
                    n_ph = PH_FEED;
                end
            endcase
        end

        if (do_close) begin
            e_emit   = 1'b1;
            e_res    = f_close(r_mode, r_found);
            n_found  = r_found + 4'd1;
            n_hcnt   = '0;
            n_sp_vld = 1'b0;
            n_skip   = 1'b0;
            n_mode   = M_START;
        end

        if (hold_we) begin
            if (r_hcnt < HCW'(HOLD_CAP)) begin
                n_hcnt = r_hcnt + HCW'(1);
                if (it.code == CH_SPACE && !r_sp_vld) begin
                    n_sp_vld = 1'b1;
                    n_sp_idx = r_hcnt;
                end
            end
        end
    end

    // The newest result waits in the pending slot until it is known whether
    // it closes the item's run.
    always_comb begin
        move     = r_p_vld && go && (r_p_last || e_emit || e_done);
        n_p      = r_p;
        n_p_vld  = r_p_vld;
        n_p_last = r_p_last;
        n_o      = r_o;
        n_o_vld  = r_o_vld;
        if (move) begin
            n_o             = r_p;
            n_o.last_of_run = r_p_last || (e_done && !e_emit);
            n_o_vld         = 1'b1;
        end else if (out_space) begin
            n_o_vld = 1'b0;
        end
        if (e_emit) begin
            n_p      = e_res;
            n_p_vld  = 1'b1;
            n_p_last = e_done;
        end else if (move) begin
            n_p_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_START;
            r_zp     <= 1'b0;
            r_skip   <= 1'b0;
            r_found  <= 4'd0;
            r_cmt    <= 1'b0;
            r_hcnt   <= '0;
            r_sp_vld <= 1'b0;
            r_sp_idx <= '0;
            r_ph     <= PH_FEED;
            r_fi     <= '0;
            r_fn     <= '0;
            r_post   <= P_TOK;
            r_p_vld  <= 1'b0;
            r_p_last <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_zp     <= n_zp;
            r_skip   <= n_skip;
            r_found  <= n_found;
            r_cmt    <= n_cmt;
            r_hcnt   <= n_hcnt;
            r_sp_vld <= n_sp_vld;
            r_sp_idx <= n_sp_idx;
            r_ph     <= n_ph;
            r_fi     <= n_fi;
            r_fn     <= n_fn;
            r_post   <= n_post;
            r_p_vld  <= n_p_vld;
            r_p_last <= n_p_last;
            r_o_vld  <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_o <= n_o;
        if (hold_we && (r_hcnt < HCW'(HOLD_CAP))) begin
            r_held[r_hcnt[HIW-1:0]] <= it.ch;
        end
    end

endmodule

FILE: hdl/aot_checker.sv
module aot_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  aot_pkg::t_in_item   i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  aot_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic [3:0]          i_cfg_data
);
    import aot_pkg::*;

    // A stalled result holds until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output result changed while stalled");

    // A line-finished result carries only the count and always ends its run.
    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_LINE) |->
            (o_out_data.operand_type == TYPE_REG) && (o_out_data.part == PART_PLAIN)
            && (o_out_data.text_char == 8'd0) && (o_out_data.operand_index == 3'd0)
            && o_out_data.last_of_run)
        else $error("malformed line-finished result");

    // A close result carries no character, part or count.
    a_close_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_CLOSE) |->
            (o_out_data.part == PART_PLAIN) && (o_out_data.text_char == 8'd0)
            && (o_out_data.operand_total == 4'd0))
        else $error("malformed close result");

    // A token never carries a zero byte, which always ends the text.
    a_token_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_TOKEN) |->
            (o_out_data.text_char != 8'd0) && (o_out_data.operand_total == 4'd0)
            && (o_out_data.operand_type <= TYPE_OTHER))
        else $error("malformed token result");

endmodule

bind asm_operand_tokenizer_top aot_checker u_aot_checker (.*);
